### hw/rtl/gpcl_pkg.sv
// gpcl_pkg: shared types and constants for the gpio port with config lock
// transaction structs, register select codes, lock key step encoding
// no dependencies
package gpcl_pkg;

    typedef struct packed {
        logic        func;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } t_out_item;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [2:0] SEL_CFG_LOW   = 3'd0;
    localparam logic [2:0] SEL_CFG_HIGH  = 3'd1;
    localparam logic [2:0] SEL_INPUT     = 3'd2;
    localparam logic [2:0] SEL_OUTPUT    = 3'd3;
    localparam logic [2:0] SEL_SET_RESET = 3'd4;
    localparam logic [2:0] SEL_RESET     = 3'd5;
    localparam logic [2:0] SEL_LOCK      = 3'd6;

    localparam logic [31:0] CFG_RESET = 32'h4444_4444;
    localparam int          KEY_POS   = 16;
    localparam int          PINS      = 16;
    localparam int          HALF_PINS = 8;

    typedef enum logic [1:0] {
        KEY_IDLE  = 2'd0,
        KEY_ONE   = 2'd1,
        KEY_ZERO  = 2'd2,
        KEY_ONE_B = 2'd3
    } t_key_step;

endpackage

### hw/rtl/gpcl_regfile.sv
// gpcl_regfile: port registers, access decode and lock key sequencer
// computes one transaction's result and updates state when enabled
// depends on gpcl_pkg
module gpcl_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  gpcl_pkg::t_in_item  i_item,
    output gpcl_pkg::t_out_item o_result
);

    logic [31:0]         r_cfg_low;
    logic [31:0]         r_cfg_high;
    logic [15:0]         r_out_data;
    logic [15:0]         r_lock_mask;
    gpcl_pkg::t_key_step r_key_step;
    logic                r_key_bit;

    logic [31:0]         n_cfg_low;
    logic [31:0]         n_cfg_high;
    logic [15:0]         n_out_data;
    logic [15:0]         n_lock_mask;
    gpcl_pkg::t_key_step n_key_step;
    logic                n_key_bit;

    logic [31:0]         keep_low;
    logic [31:0]         keep_high;
    logic [31:0]         rd;
    logic [15:0]         wr_mask;
    logic                wr_key;
    logic                same_mask;

    always_comb begin
        for (int i = 0; i < gpcl_pkg::HALF_PINS; i++) begin
            keep_low[4*i +: 4]  = {4{r_key_bit & r_lock_mask[i]}};
            keep_high[4*i +: 4] = {4{r_key_bit & r_lock_mask[gpcl_pkg::HALF_PINS + i]}};
        end
    end

    assign wr_mask   = i_item.write_data[15:0];
    assign wr_key    = i_item.write_data[gpcl_pkg::KEY_POS];
    assign same_mask = (wr_mask == r_lock_mask);

    always_comb begin
        n_cfg_low   = r_cfg_low;
        n_cfg_high  = r_cfg_high;
        n_out_data  = r_out_data;
        n_lock_mask = r_lock_mask;
        n_key_step  = r_key_step;
        n_key_bit   = r_key_bit;
        rd          = '0;
        if (i_item.func == gpcl_pkg::FUNC_WRITE) begin
            unique case (i_item.reg_select)
                gpcl_pkg::SEL_CFG_LOW: begin
                    n_cfg_low = (r_cfg_low & keep_low) | (i_item.write_data & ~keep_low);
                end
                gpcl_pkg::SEL_CFG_HIGH: begin
                    n_cfg_high = (r_cfg_high & keep_high) | (i_item.write_data & ~keep_high);
                end
                gpcl_pkg::SEL_OUTPUT: begin
                    n_out_data = i_item.write_data[15:0];
                end
                gpcl_pkg::SEL_SET_RESET: begin
                    n_out_data = (r_out_data & ~i_item.write_data[31:16])
                               | i_item.write_data[15:0];
                end
                gpcl_pkg::SEL_RESET: begin
                    n_out_data = r_out_data & ~i_item.write_data[15:0];
                end
                gpcl_pkg::SEL_LOCK: begin
                    if (!r_key_bit) begin
                        if (r_key_step == gpcl_pkg::KEY_ONE && !wr_key && same_mask) begin
                            n_key_step = gpcl_pkg::KEY_ZERO;
                        end else if (r_key_step == gpcl_pkg::KEY_ZERO && wr_key && same_mask) begin
                            n_key_step = gpcl_pkg::KEY_ONE_B;
                        end else begin
                            n_key_step = wr_key ? gpcl_pkg::KEY_ONE : gpcl_pkg::KEY_IDLE;
                        end
                        n_lock_mask = wr_mask;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            unique case (i_item.reg_select)
                gpcl_pkg::SEL_CFG_LOW:  rd = r_cfg_low;
                gpcl_pkg::SEL_CFG_HIGH: rd = r_cfg_high;
                gpcl_pkg::SEL_INPUT:    rd = {16'h0000, i_item.pin_levels};
                gpcl_pkg::SEL_OUTPUT:   rd = {16'h0000, r_out_data};
                gpcl_pkg::SEL_LOCK: begin
                    rd = {15'h0000, r_key_bit, r_lock_mask};
                    if (r_key_step == gpcl_pkg::KEY_ONE_B) begin
                        n_key_bit = 1'b1;
                    end
                    n_key_step = gpcl_pkg::KEY_IDLE;
                end
                default: rd = '0;
            endcase
        end
    end

    assign o_result.read_data   = rd;
    assign o_result.pin_drive   = n_out_data;
    assign o_result.lock_active = n_key_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= gpcl_pkg::CFG_RESET;
            r_cfg_high  <= gpcl_pkg::CFG_RESET;
            r_out_data  <= '0;
            r_lock_mask <= '0;
            r_key_step  <= gpcl_pkg::KEY_IDLE;
            r_key_bit   <= 1'b0;
        end else if (i_en) begin
            r_cfg_low   <= n_cfg_low;
            r_cfg_high  <= n_cfg_high;
            r_out_data  <= n_out_data;
            r_lock_mask <= n_lock_mask;
            r_key_step  <= n_key_step;
            r_key_bit   <= n_key_bit;
        end
    end

endmodule

### hw/rtl/gpio_port_with_config_lock_core.sv
// gpio_port_with_config_lock_core: top level of the 16-pin gpio port with config lock
// input register, register file stage, result register; depends on gpcl_pkg, gpcl_regfile
//
// channel | valid      | stall       | payload
// --------+------------+-------------+----------------------------
// in      | i_in_valid | o_in_stall  | i_in_data  (t_in_item)
// out     | o_out_valid| i_out_stall | o_out_data (t_out_item)
//
// one transaction per cycle sustained while the result side does not stall; an accepted access passes
// the input register, then the decode logic, then the result register that presents its result
// synchronous active-low reset clears valids and restores all port registers
// a stalled result holds in the result register while the input register still takes one more
module gpio_port_with_config_lock_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gpcl_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gpcl_pkg::t_out_item o_out_data
);

    logic                r_in_valid;
    gpcl_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    gpcl_pkg::t_out_item r_out_data;

    gpcl_pkg::t_out_item result;
    logic                advance;
    logic                in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    gpcl_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### tb/gpcl_checker.sv
// gpcl_checker: transaction checker for gpio_port_with_config_lock_core
// watches both channels, predicts each access result and compares field by field
// depends on gpcl_pkg
module gpcl_checker
    import gpcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0] cfg_low;
    logic [31:0] cfg_high;
    logic [15:0] pin_out;
    logic [15:0] lock_mask;
    t_key_step   key_step;
    logic        lock_on;

    t_out_item   expected_results[$];
    t_out_item   predicted;
    t_out_item   want;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic [31:0] locked_nibbles(input int first_pin);
        logic [31:0] m;
        m = '0;
        if (lock_on) begin
            for (int i = 0; i < HALF_PINS; i++) begin
                if (lock_mask[first_pin + i]) m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    task automatic apply_access(input t_in_item acc, output t_out_item res);
        logic [31:0] keep;
        logic [15:0] mask;
        logic        key;
        res = '0;
        if (acc.func == FUNC_WRITE) begin
            case (acc.reg_select)
                SEL_CFG_LOW: begin
                    keep = locked_nibbles(0);
                    cfg_low = (cfg_low & keep) | (acc.write_data & ~keep);
                end
                SEL_CFG_HIGH: begin
                    keep = locked_nibbles(HALF_PINS);
                    cfg_high = (cfg_high & keep) | (acc.write_data & ~keep);
                end
                SEL_OUTPUT: pin_out = acc.write_data[15:0];
                SEL_SET_RESET: begin
                    pin_out = (pin_out & ~acc.write_data[31:16]) | acc.write_data[15:0];
                end
                SEL_RESET: pin_out = pin_out & ~acc.write_data[15:0];
                SEL_LOCK: begin
                    if (!lock_on) begin
                        mask = acc.write_data[15:0];
                        key = acc.write_data[KEY_POS];
                        if (key_step == KEY_ONE && !key && mask == lock_mask) begin
                            key_step = KEY_ZERO;
                        end else if (key_step == KEY_ZERO && key && mask == lock_mask) begin
                            key_step = KEY_ONE_B;
                        end else begin
                            key_step = key ? KEY_ONE : KEY_IDLE;
                        end
                        lock_mask = mask;
                    end
                end
                default: ;
            endcase
        end else begin
            case (acc.reg_select)
                SEL_CFG_LOW:  res.read_data = cfg_low;
                SEL_CFG_HIGH: res.read_data = cfg_high;
                SEL_INPUT:    res.read_data = {16'h0, acc.pin_levels};
                SEL_OUTPUT:   res.read_data = {16'h0, pin_out};
                SEL_LOCK: begin
                    res.read_data = {15'h0, lock_on, lock_mask};
                    if (key_step == KEY_ONE_B) lock_on = 1'b1;
                    key_step = KEY_IDLE;
                end
                default: res.read_data = '0;
            endcase
        end
        res.pin_drive = pin_out;
        res.lock_active = lock_on;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_low = CFG_RESET;
            cfg_high = CFG_RESET;
            pin_out = '0;
            lock_mask = '0;
            key_step = KEY_IDLE;
            lock_on = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no pending access: %h", i_out_data));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.read_data !== want.read_data) begin
                        report_mismatch($sformatf("read_data %h, expected %h",
                            i_out_data.read_data, want.read_data));
                    end
                    if (i_out_data.pin_drive !== want.pin_drive) begin
                        report_mismatch($sformatf("pin_drive %h, expected %h",
                            i_out_data.pin_drive, want.pin_drive));
                    end
                    if (i_out_data.lock_active !== want.lock_active) begin
                        report_mismatch($sformatf("lock_active %b, expected %b",
                            i_out_data.lock_active, want.lock_active));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_access(i_in_data, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### tb/gpio_port_with_config_lock_core_test.sv
// gpio_port_with_config_lock_core_test: top of the gpio port testbench
// drives register accesses and lock key sequences, stalls the result side, gives the verdict
// depends on gpcl_pkg, gpio_port_with_config_lock_core, gpcl_checker
module gpio_port_with_config_lock_core_test;
    import gpcl_pkg::*;

    localparam int ITEM_TOTAL     = 500;
    localparam int UNLOCKED_ITEMS = 340;
    localparam int HOLD_AT        = 120;
    localparam int DRAIN_AT       = 200;
    localparam int BURST_FROM     = 250;
    localparam int BURST_TO       = 330;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 10;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic [2:0] SEL_UNUSED = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int        fail_count;
    int        pending;
    int        accesses_sent = 0;
    int        cycle_count = 0;
    logic      idle_on = 1'b1;
    logic      hold_request = 1'b0;
    logic      hold_served = 1'b0;
    logic      hold_done = 1'b0;
    logic      drain_done = 1'b0;

    gpio_port_with_config_lock_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    gpcl_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_in_item make_access(input logic func, input logic [2:0] sel,
                                             input logic [31:0] data, input logic [15:0] pins);
        t_in_item acc;
        acc.func = func;
        acc.reg_select = sel;
        acc.write_data = data;
        acc.pin_levels = pins;
        return acc;
    endfunction

    function automatic t_in_item random_access();
        return make_access(1'($urandom_range(1)), 3'($urandom_range(7)), $urandom,
                           16'($urandom));
    endfunction

    function automatic t_in_item other_access();
        return make_access(1'($urandom_range(1)), 3'($urandom_range(5)), $urandom,
                           16'($urandom));
    endfunction

    // a lock access that breaks the key sequence at step k
    function automatic t_in_item key_breaker(input int k, input logic [15:0] mask);
        logic [31:0] data;
        int          mode;
        data = $urandom;
        data[15:0] = mask;
        data[KEY_POS] = (k != 1);
        mode = $urandom_range(2);
        if (k == 3) data = $urandom;
        else if (mode == 2 && k != 0) return make_access(FUNC_READ, SEL_LOCK, data, 16'($urandom));
        else if (mode == 1) data[15:0] = ~mask;
        else data[KEY_POS] = ~data[KEY_POS];
        return make_access(FUNC_WRITE, SEL_LOCK, data, 16'($urandom));
    endfunction

    task automatic send_access(input t_in_item acc);
        while (idle_on && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= acc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accesses_sent++;
    endtask

    task automatic send_write(input logic [2:0] sel, input logic [31:0] data);
        send_access(make_access(FUNC_WRITE, sel, data, 16'($urandom)));
    endtask

    task automatic send_read(input logic [2:0] sel, input logic [15:0] pins);
        send_access(make_access(FUNC_READ, sel, $urandom, pins));
    endtask

    // break_step 0..3 breaks the sequence there, 4 runs it to completion
    task automatic key_sequence(input logic [15:0] mask, input int break_step);
        logic [31:0] data;
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(3) == 0) send_access(other_access());
            data = $urandom;
            data[15:0] = mask;
            data[KEY_POS] = (k != 1);
            if (k == break_step) send_access(key_breaker(k, mask));
            else if (k == 3) send_access(make_access(FUNC_READ, SEL_LOCK, data, 16'($urandom)));
            else send_access(make_access(FUNC_WRITE, SEL_LOCK, data, 16'($urandom)));
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= idle_on && ($urandom_range(99) < 7);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL gpio_port_with_config_lock_core");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, pins, write-only and read-only registers, unused select
        send_read(SEL_CFG_LOW, 16'h0000);
        send_read(SEL_CFG_HIGH, 16'h0000);
        send_read(SEL_INPUT, 16'hFFFF);
        send_read(SEL_INPUT, 16'h0000);
        send_read(SEL_OUTPUT, 16'h0000);
        send_write(SEL_OUTPUT, 32'hFFFF_FFFF);
        send_write(SEL_SET_RESET, 32'hFFFF_00FF);
        send_write(SEL_RESET, 32'hFFFF_0003);
        send_read(SEL_SET_RESET, 16'hFFFF);
        send_read(SEL_RESET, 16'hFFFF);
        send_write(SEL_INPUT, 32'hFFFF_FFFF);
        send_read(SEL_OUTPUT, 16'h0000);
        send_write(SEL_UNUSED, 32'hFFFF_FFFF);
        send_read(SEL_UNUSED, 16'hFFFF);
        send_write(SEL_CFG_LOW, 32'hFFFF_FFFF);
        send_write(SEL_CFG_HIGH, 32'h0000_0000);
        send_read(SEL_CFG_LOW, 16'h0000);
        send_read(SEL_CFG_HIGH, 16'h0000);
        // broken key sequence, lock read aborts it
        send_write(SEL_LOCK, 32'h0001_FFFF);
        send_write(SEL_LOCK, 32'h0001_0000);
        send_read(SEL_LOCK, 16'h0000);
        send_write(SEL_SET_RESET, 32'hFFFF_0000);
        send_write(SEL_LOCK, 32'hFFFF_FFFF);
        send_read(SEL_LOCK, 16'hFFFF);

        while (accesses_sent < UNLOCKED_ITEMS) begin
            if (accesses_sent >= HOLD_AT && !hold_done) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (accesses_sent >= DRAIN_AT && !drain_done) begin
                wait_for_results();
                drain_done = 1'b1;
            end
            idle_on = !(accesses_sent >= BURST_FROM && accesses_sent < BURST_TO);
            if ($urandom_range(2) == 0) key_sequence(16'($urandom), $urandom_range(3));
            else send_access(random_access());
        end
        idle_on = 1'b1;

        // complete key sequence, then locked configuration
        key_sequence(16'($urandom), 4);
        send_write(SEL_CFG_LOW, 32'hFFFF_FFFF);
        send_write(SEL_CFG_HIGH, 32'h0000_0000);
        send_read(SEL_CFG_LOW, 16'h0000);
        send_read(SEL_CFG_HIGH, 16'h0000);
        send_write(SEL_LOCK, 32'h0000_0000);
        send_read(SEL_LOCK, 16'h0000);

        while (accesses_sent < ITEM_TOTAL) begin
            if ($urandom_range(5) == 0) key_sequence(16'($urandom), $urandom_range(4));
            else send_access(random_access());
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS gpio_port_with_config_lock_core");
        end else begin
            $display("FAIL gpio_port_with_config_lock_core");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/gpcl_pkg.sv
hw/rtl/gpcl_regfile.sv
hw/rtl/gpio_port_with_config_lock_core.sv
tb/gpcl_checker.sv
tb/gpio_port_with_config_lock_core_test.sv
